@@ rtl/core/audio_baseline_envelope_tracker_defines.svh @@
// assertion helpers for the baseline and envelope tracker
`ifndef AUDIO_BASELINE_ENVELOPE_TRACKER_DEFINES_SVH
`define AUDIO_BASELINE_ENVELOPE_TRACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ABET_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ABET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/abet_pkg.sv @@
package abet_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_QUIET_THRESHOLD  = 3'd0,
        CFG_SMOOTHING_FACTOR = 3'd1,
        CFG_BASELINE_FACTOR  = 3'd2,
        CFG_REBASE_ENABLE    = 3'd3,
        CFG_INITIAL_BASELINE = 3'd4
    } cfg_index_t;

    // command field
    localparam logic CMD_RESTART = 1'b1;

    // register widths and reset values
    localparam int QT_W      = 13;
    localparam int FACTOR_W  = 17;
    localparam int INIT_BL_W = 12;

    localparam logic [QT_W-1:0]      QT_RESET      = 13'd0;
    localparam logic [FACTOR_W-1:0]  FACTOR_RESET  = 17'd0;
    localparam logic                 REBASE_RESET  = 1'b1;
    localparam logic [INIT_BL_W-1:0] INIT_BL_RESET = 12'd2048;

    // q1.16 factor arithmetic
    localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'd65536;
    localparam int                  Q_SHIFT = 16;

    // timestamp and index fields
    localparam int IDX_W       = 32;
    localparam int TIME_US_W   = 32;
    localparam int TIME_MS_W   = 23;
    localparam int MS_RECIP_W  = 29;
    localparam int MS_SHIFT    = 38;
    localparam int TIME_PROD_W = TIME_US_W + MS_RECIP_W;
    // floor(us / 1000) == (us * MS_RECIP) >> 38 for every 32-bit us
    localparam logic [MS_RECIP_W-1:0] MS_RECIP = 29'd274877907;

    // status of the calibration divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/core/abet_ema.sv @@
module abet_ema #(
    parameter int ACC_W     = 28,
    parameter int X_W       = 12,
    parameter int FRAC_BITS = 16
) (
    input  logic [ACC_W-1:0]              old_acc,
    input  logic [X_W-1:0]                x,
    input  logic [abet_pkg::FACTOR_W-1:0] factor,
    output logic [ACC_W-1:0]              new_acc
);

    localparam int KEEP_W   = ACC_W + abet_pkg::FACTOR_W;
    localparam int MIX_W    = X_W + abet_pkg::FACTOR_W;
    localparam int MIX_SH_W = MIX_W + FRAC_BITS;

    logic [abet_pkg::FACTOR_W-1:0] f_sat;
    logic [abet_pkg::FACTOR_W-1:0] f_keep;
    logic [KEEP_W-1:0]             keep_prod;
    logic [MIX_W-1:0]              mix_prod;
    logic [MIX_SH_W-1:0]           mix_shifted;
    logic [ACC_W-1:0]              keep_part;
    logic [ACC_W-1:0]              mix_part;

    // factors above one saturate to one
    assign f_sat  = (factor > abet_pkg::ONE_Q16) ? abet_pkg::ONE_Q16 : factor;
    assign f_keep = abet_pkg::ONE_Q16 - f_sat;

    assign keep_prod   = KEEP_W'(old_acc) * KEEP_W'(f_keep);
    assign mix_prod    = MIX_W'(x) * MIX_W'(f_sat);
    assign mix_shifted = {mix_prod, {FRAC_BITS{1'b0}}};

    // each product truncated on its own, the sum never exceeds the larger input
    assign keep_part = ACC_W'(keep_prod >> abet_pkg::Q_SHIFT);
    assign mix_part  = ACC_W'(mix_shifted >> abet_pkg::Q_SHIFT);
    assign new_acc   = keep_part + mix_part;

endmodule

@@ rtl/core/abet_cal_div.sv @@
module abet_cal_div #(
    parameter int SAMPLE_BITS = 12,
    parameter int CAL_SAMPLES = 200,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [SAMPLE_BITS+$clog2(CAL_SAMPLES+1)-1:0] sum,
    output abet_pkg::div_stat_t                    stat,
    output logic [SAMPLE_BITS+FRAC_BITS-1:0]       baseline
);

    localparam int CNT_W    = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W    = SAMPLE_BITS + CNT_W;
    localparam int RECIP_SH = SUM_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W  = SUM_W + 2;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int TAB_N    = 1 << CNT_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SH) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam logic [CNT_W-1:0]   CAL_C = CNT_W'(CAL_SAMPLES);

    logic                   q_vld_reg;
    logic [SAMPLE_BITS-1:0] q_reg;
    logic [SUM_W-1:0]       sum_hold_reg;
    logic                   r_vld_reg;
    logic [SAMPLE_BITS-1:0] q_out_reg;
    logic [CNT_W-1:0]       r_reg;

    logic [PROD_W-1:0]      q_prod;
    logic [SAMPLE_BITS-1:0] q_next;
    logic [SUM_W-1:0]       qc;
    logic [SUM_W-1:0]       r_full;
    logic [CNT_W-1:0]       r_next;
    logic [FRAC_BITS-1:0]   frac_tab [TAB_N];

    // (remainder << FRAC_BITS) / CAL_SAMPLES for every possible remainder
    for (genvar i = 0; i < TAB_N; i++) begin : g_frac
        if (i < CAL_SAMPLES) begin : g_used
            assign frac_tab[i] = FRAC_BITS'((64'(i) << FRAC_BITS) / CAL_SAMPLES);
        end
        else begin : g_unused
            assign frac_tab[i] = '0;
        end
    end

    // exact quotient by reciprocal, the sum never exceeds CAL_SAMPLES full-scale samples
    assign q_prod = PROD_W'(sum) * PROD_W'(RECIP);
    assign q_next = SAMPLE_BITS'(q_prod >> RECIP_SH);

    assign qc     = SUM_W'(q_reg) * SUM_W'(CAL_C);
    assign r_full = sum_hold_reg - qc;
    assign r_next = r_full[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else
        begin
            q_vld_reg <= start;
            r_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg        <= q_next;
            sum_hold_reg <= sum;
        end
        if (q_vld_reg)
        begin
            q_out_reg <= q_reg;
            r_reg     <= r_next;
        end
    end

    assign stat.busy = q_vld_reg || r_vld_reg;
    assign stat.done = r_vld_reg;
    assign baseline  = {q_out_reg, frac_tab[r_reg]};

endmodule

@@ rtl/core/audio_baseline_envelope_tracker.sv @@
// channel  dir  handshake            fields
// cfg      in   cfg_write            cfg_index, cfg_data
// in       in   in_valid, in_ready   cmd, sample, sample_time_us
// out      out  out_valid, out_ready sample_index, time_ms, raw_sample, centered_sample,
//                                    level, smoothed_level, baseline_whole, gate_open
//
// one transaction per cycle unless output or divider stalls: an input register feeds
// compute logic that updates baseline and envelope and loads the output register
// the last calibration sample starts a two-stage reciprocal divider, input held while busy
// asynchronous reset loads the register defaults and arms calibration, no clearing pass
// a stalled output holds back only an input register that carries a result-giving sample
`include "audio_baseline_envelope_tracker_defines.svh"

module audio_baseline_envelope_tracker #(
    parameter int SAMPLE_BITS = 12,
    parameter int CAL_SAMPLES = 200,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [abet_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [abet_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic [SAMPLE_BITS-1:0]               sample,
    input  logic [abet_pkg::TIME_US_W-1:0]       sample_time_us,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [abet_pkg::IDX_W-1:0]           sample_index,
    output logic [abet_pkg::TIME_MS_W-1:0]       time_ms,
    output logic [SAMPLE_BITS-1:0]               raw_sample,
    output logic signed [SAMPLE_BITS:0]          centered_sample,
    output logic [SAMPLE_BITS-1:0]               level,
    output logic [SAMPLE_BITS-1:0]               smoothed_level,
    output logic [SAMPLE_BITS-1:0]               baseline_whole,
    output logic                                 gate_open
);

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int ACC_W = SAMPLE_BITS + FRAC_BITS;
    localparam int CMP_W = (SAMPLE_BITS > abet_pkg::QT_W) ? SAMPLE_BITS : abet_pkg::QT_W;
    localparam logic [CNT_W-1:0] CAL_C = CNT_W'(CAL_SAMPLES);

    // configuration
    logic [abet_pkg::QT_W-1:0]      quiet_threshold_reg;
    logic [abet_pkg::FACTOR_W-1:0]  smoothing_factor_reg;
    logic [abet_pkg::FACTOR_W-1:0]  baseline_factor_reg;
    logic                           rebase_enable_reg;
    logic [abet_pkg::INIT_BL_W-1:0] initial_baseline_reg;

    // input register
    logic                           s1_valid_reg;
    logic                           s1_cmd_reg;
    logic [SAMPLE_BITS-1:0]         s1_sample_reg;
    logic [abet_pkg::TIME_US_W-1:0] s1_time_reg;

    // tracker state
    logic [ACC_W-1:0]          baseline_acc_reg, baseline_acc_next;
    logic [ACC_W-1:0]          envelope_acc_reg, envelope_acc_next;
    logic [SUM_W-1:0]          calib_sum_reg, calib_sum_next;
    logic [CNT_W-1:0]          calib_count_reg, calib_count_next;
    logic                      calibrating_reg, calibrating_next;
    logic [abet_pkg::IDX_W-1:0] processed_count_reg, processed_count_next;

    logic out_valid_reg, out_valid_next;

    // compute cycle
    logic                               s1_gives_result;
    logic                               out_free;
    logic                               s1_fire;
    logic                               out_load;
    logic                               div_start;
    abet_pkg::div_stat_t                div_stat;
    logic [ACC_W-1:0]                   div_baseline;
    logic [SAMPLE_BITS-1:0]             whole;
    logic signed [SAMPLE_BITS:0]        centered;
    logic [SAMPLE_BITS:0]               centered_neg;
    logic [SAMPLE_BITS-1:0]             mag;
    logic                               quiet;
    logic [SAMPLE_BITS-1:0]             level_c;
    logic [ACC_W-1:0]                   baseline_upd;
    logic [ACC_W-1:0]                   baseline_new;
    logic [ACC_W-1:0]                   envelope_new;
    logic [SAMPLE_BITS-1:0]             init_whole;
    logic [SUM_W-1:0]                   sum_inc;
    logic [CNT_W-1:0]                   count_inc;
    logic [abet_pkg::TIME_PROD_W-1:0]   time_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_threshold_reg  <= abet_pkg::QT_RESET;
            smoothing_factor_reg <= abet_pkg::FACTOR_RESET;
            baseline_factor_reg  <= abet_pkg::FACTOR_RESET;
            rebase_enable_reg    <= abet_pkg::REBASE_RESET;
            initial_baseline_reg <= abet_pkg::INIT_BL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                abet_pkg::CFG_QUIET_THRESHOLD:
                    quiet_threshold_reg <= cfg_data[abet_pkg::QT_W-1:0];
                abet_pkg::CFG_SMOOTHING_FACTOR:
                    smoothing_factor_reg <= cfg_data[abet_pkg::FACTOR_W-1:0];
                abet_pkg::CFG_BASELINE_FACTOR:
                    baseline_factor_reg <= cfg_data[abet_pkg::FACTOR_W-1:0];
                abet_pkg::CFG_REBASE_ENABLE:
                    rebase_enable_reg <= cfg_data[0];
                abet_pkg::CFG_INITIAL_BASELINE:
                    initial_baseline_reg <= cfg_data[abet_pkg::INIT_BL_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // handshake: only a result-giving sample needs room in the output register
    assign s1_gives_result = (s1_cmd_reg != abet_pkg::CMD_RESTART) && !calibrating_reg;
    assign out_free        = !out_valid_reg || out_ready;
    assign s1_fire         = s1_valid_reg && !div_stat.busy && (!s1_gives_result || out_free);
    assign out_load        = s1_fire && s1_gives_result;
    assign in_ready        = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_cmd_reg    <= cmd;
            s1_sample_reg <= sample;
            s1_time_reg   <= sample_time_us;
        end
    end

    // centring and gating
    assign whole        = baseline_acc_reg[ACC_W-1:FRAC_BITS];
    assign centered     = $signed({1'b0, s1_sample_reg}) - $signed({1'b0, whole});
    assign centered_neg = -centered;
    assign mag          = centered[SAMPLE_BITS] ? centered_neg[SAMPLE_BITS-1:0]
                                                : centered[SAMPLE_BITS-1:0];
    assign quiet        = CMP_W'(mag) < CMP_W'(quiet_threshold_reg);
    assign level_c      = quiet ? '0 : mag;

    abet_ema #(
        .ACC_W     (ACC_W),
        .X_W       (SAMPLE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_baseline_ema (
        .old_acc (baseline_acc_reg),
        .x       (s1_sample_reg),
        .factor  (baseline_factor_reg),
        .new_acc (baseline_upd)
    );

    abet_ema #(
        .ACC_W     (ACC_W),
        .X_W       (SAMPLE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_envelope_ema (
        .old_acc (envelope_acc_reg),
        .x       (level_c),
        .factor  (smoothing_factor_reg),
        .new_acc (envelope_new)
    );

    assign baseline_new = quiet ? baseline_upd : baseline_acc_reg;

    // calibration accumulation
    assign init_whole = SAMPLE_BITS'(initial_baseline_reg);
    assign sum_inc    = calib_sum_reg + SUM_W'(s1_sample_reg);
    assign count_inc  = calib_count_reg + CNT_W'(1);

    abet_cal_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CAL_SAMPLES (CAL_SAMPLES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_cal_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sum      (sum_inc),
        .stat     (div_stat),
        .baseline (div_baseline)
    );

    always_comb
    begin
        baseline_acc_next    = baseline_acc_reg;
        envelope_acc_next    = envelope_acc_reg;
        calib_sum_next       = calib_sum_reg;
        calib_count_next     = calib_count_reg;
        calibrating_next     = calibrating_reg;
        processed_count_next = processed_count_reg;
        div_start            = 1'b0;
        priority if (div_stat.done)
        begin
            baseline_acc_next = div_baseline;
        end
        else if (s1_fire)
        begin
            priority if (s1_cmd_reg == abet_pkg::CMD_RESTART)
            begin
                processed_count_next = '0;
                calib_sum_next       = '0;
                calib_count_next     = '0;
                calibrating_next     = rebase_enable_reg;
                if (!rebase_enable_reg)
                begin
                    baseline_acc_next = {init_whole, {FRAC_BITS{1'b0}}};
                end
            end
            else if (calibrating_reg)
            begin
                calib_sum_next   = sum_inc;
                calib_count_next = count_inc;
                if (count_inc == CAL_C)
                begin
                    div_start         = 1'b1;
                    envelope_acc_next = '0;
                    calib_sum_next    = '0;
                    calib_count_next  = '0;
                    calibrating_next  = 1'b0;
                end
            end
            else
            begin
                baseline_acc_next    = baseline_new;
                envelope_acc_next    = envelope_new;
                processed_count_next = processed_count_reg + abet_pkg::IDX_W'(1);
            end
        end
        else
        begin
            // idle cycle, state holds
            div_start = 1'b0;
        end
    end

    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_acc_reg    <= {SAMPLE_BITS'(abet_pkg::INIT_BL_RESET), {FRAC_BITS{1'b0}}};
            envelope_acc_reg    <= '0;
            calib_sum_reg       <= '0;
            calib_count_reg     <= '0;
            calibrating_reg     <= abet_pkg::REBASE_RESET;
            processed_count_reg <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            baseline_acc_reg    <= baseline_acc_next;
            envelope_acc_reg    <= envelope_acc_next;
            calib_sum_reg       <= calib_sum_next;
            calib_count_reg     <= calib_count_next;
            calibrating_reg     <= calibrating_next;
            processed_count_reg <= processed_count_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // microseconds to milliseconds by reciprocal
    assign time_prod = abet_pkg::TIME_PROD_W'(s1_time_reg)
                     * abet_pkg::TIME_PROD_W'(abet_pkg::MS_RECIP);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_index    <= processed_count_reg;
            time_ms         <= time_prod[abet_pkg::MS_SHIFT +: abet_pkg::TIME_MS_W];
            raw_sample      <= s1_sample_reg;
            centered_sample <= centered;
            level           <= level_c;
            smoothed_level  <= envelope_new[ACC_W-1:FRAC_BITS];
            baseline_whole  <= baseline_new[ACC_W-1:FRAC_BITS];
            gate_open       <= (level_c != '0);
        end
    end

    assign out_valid = out_valid_reg;

    `ABET_ASSERT_NEXT(a_div_after_cal, div_start, div_stat.busy && !calibrating_reg,
        "divider not running after calibration end")
    `ABET_ASSERT_IMPLIES(a_hold_while_div, div_stat.busy, !s1_fire && !calibrating_reg,
        "transaction processed while baseline division runs")
    `ABET_ASSERT_NEXT(a_index_steps, out_load,
        processed_count_reg == $past(processed_count_reg) + 32'd1,
        "sample count did not advance with a result")

endmodule

@@ sim/tb_audio_baseline_envelope_tracker.sv @@
`timescale 1ns / 100ps

localparam int CAL_LENGTH = 200;
localparam int FRAC       = 16;

typedef struct packed {
    logic [31:0]        sample_index;
    logic [22:0]        time_ms;
    logic [11:0]        raw_sample;
    logic signed [12:0] centered_sample;
    logic [11:0]        level;
    logic [11:0]        smoothed_level;
    logic [11:0]        baseline_whole;
    logic               gate_open;
} tracker_result_t;

class tracker_scoreboard;
    bit [12:0]       quiet_thr;
    bit [16:0]       smooth_f;
    bit [16:0]       base_f;
    bit              rebase_en;
    bit [11:0]       init_bl;

    bit [63:0]       baseline_acc;
    bit [63:0]       envelope_acc;
    bit [19:0]       cal_sum;
    int unsigned     cal_count;
    bit              calibrating;
    bit [31:0]       processed;

    tracker_result_t expected_q[$];
    int              mismatches;

    function new();
        quiet_thr    = abet_pkg::QT_RESET;
        smooth_f     = abet_pkg::FACTOR_RESET;
        base_f       = abet_pkg::FACTOR_RESET;
        rebase_en    = abet_pkg::REBASE_RESET;
        init_bl      = abet_pkg::INIT_BL_RESET;
        baseline_acc = 64'(abet_pkg::INIT_BL_RESET) << FRAC;
        envelope_acc = 0;
        cal_sum      = 0;
        cal_count    = 0;
        calibrating  = abet_pkg::REBASE_RESET;
        processed    = 0;
        mismatches   = 0;
    endfunction

    function void write_reg(abet_pkg::cfg_index_t idx, logic [16:0] val);
        case (idx)
            abet_pkg::CFG_QUIET_THRESHOLD:  quiet_thr = val[12:0];
            abet_pkg::CFG_SMOOTHING_FACTOR: smooth_f  = val;
            abet_pkg::CFG_BASELINE_FACTOR:  base_f    = val;
            abet_pkg::CFG_REBASE_ENABLE:    rebase_en = val[0];
            abet_pkg::CFG_INITIAL_BASELINE: init_bl   = val[11:0];
            default: ;
        endcase
    endfunction

    // exponential step toward x, weights saturate at one, each product truncated
    function bit [63:0] track_toward(bit [63:0] old, bit [63:0] x, bit [16:0] f);
        bit [63:0] w;
        w = (f > abet_pkg::ONE_Q16) ? 64'(abet_pkg::ONE_Q16) : 64'(f);
        return ((old * (64'd65536 - w)) >> abet_pkg::Q_SHIFT)
             + (((x << FRAC) * w) >> abet_pkg::Q_SHIFT);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_input(logic c, logic [11:0] s, logic [31:0] t);
        tracker_result_t r;
        bit [11:0]       whole;
        int              ctr;
        int              mag;
        bit [63:0]       lvl;
        if (c == abet_pkg::CMD_RESTART) begin
            processed   = 0;
            cal_sum     = 0;
            cal_count   = 0;
            calibrating = rebase_en;
            if (!calibrating)
                baseline_acc = 64'(init_bl) << FRAC;
            return;
        end
        if (calibrating) begin
            cal_sum   = cal_sum + s;
            cal_count = cal_count + 1;
            if (cal_count >= CAL_LENGTH) begin
                baseline_acc = (64'(cal_sum) << FRAC) / CAL_LENGTH;
                envelope_acc = 0;
                cal_sum      = 0;
                cal_count    = 0;
                calibrating  = 1'b0;
            end
            return;
        end
        whole = baseline_acc[27:16];
        ctr   = s;
        ctr   = ctr - int'(whole);
        mag   = (ctr < 0) ? -ctr : ctr;
        lvl   = mag;
        if (mag < int'(quiet_thr)) begin
            baseline_acc = track_toward(baseline_acc, 64'(s), base_f);
            lvl = 0;
        end
        envelope_acc = track_toward(envelope_acc, lvl, smooth_f);

        r.sample_index    = processed;
        r.time_ms         = 23'(t / 1000);
        r.raw_sample      = s;
        r.centered_sample = 13'(ctr);
        r.level           = lvl[11:0];
        r.smoothed_level  = envelope_acc[27:16];
        r.baseline_whole  = baseline_acc[27:16];
        r.gate_open       = (lvl != 0);
        expected_q.push_back(r);
        processed = processed + 1;
    endfunction

    function string describe(tracker_result_t r);
        return $sformatf("idx=%0d ms=%0d raw=%0d ctr=%0d lvl=%0d env=%0d base=%0d gate=%0d",
                         r.sample_index, r.time_ms, r.raw_sample, r.centered_sample,
                         r.level, r.smoothed_level, r.baseline_whole, r.gate_open);
    endfunction

    function void check_result(tracker_result_t got);
        tracker_result_t want;
        string           diff;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result with nothing outstanding: %s", describe(got));
            return;
        end
        want = expected_q.pop_front();
        diff = "";
        if (got.sample_index != want.sample_index)       diff = {diff, " sample_index"};
        if (got.time_ms != want.time_ms)                 diff = {diff, " time_ms"};
        if (got.raw_sample != want.raw_sample)           diff = {diff, " raw_sample"};
        if (got.centered_sample != want.centered_sample) diff = {diff, " centered_sample"};
        if (got.level != want.level)                     diff = {diff, " level"};
        if (got.smoothed_level != want.smoothed_level)   diff = {diff, " smoothed_level"};
        if (got.baseline_whole != want.baseline_whole)   diff = {diff, " baseline_whole"};
        if (got.gate_open != want.gate_open)             diff = {diff, " gate_open"};
        if (diff != "") begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in%s\n  expected %s\n  actual   %s",
                         diff, describe(want), describe(got));
        end
    endfunction
endclass

module tb_audio_baseline_envelope_tracker;

    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   DRAIN_CYCLES   = 8;
    localparam logic CMD_SAMPLE     = ~abet_pkg::CMD_RESTART;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [abet_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [abet_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic                             cmd;
    logic [11:0]                      sample;
    logic [31:0]                      sample_time_us;
    logic                             out_valid;
    logic                             out_ready;
    logic [31:0]                      sample_index;
    logic [22:0]                      time_ms;
    logic [11:0]                      raw_sample;
    logic signed [12:0]               centered_sample;
    logic [11:0]                      level;
    logic [11:0]                      smoothed_level;
    logic [11:0]                      baseline_whole;
    logic                             gate_open;

    tracker_scoreboard sb;
    int                gap_pct   = 0;
    int                stall_pct = 0;
    int                idle_cycles = 0;

    audio_baseline_envelope_tracker DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .sample          (sample),
        .sample_time_us  (sample_time_us),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sample_index    (sample_index),
        .time_ms         (time_ms),
        .raw_sample      (raw_sample),
        .centered_sample (centered_sample),
        .level           (level),
        .smoothed_level  (smoothed_level),
        .baseline_whole  (baseline_whole),
        .gate_open       (gate_open)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver side: random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(cmd, sample, sample_time_us);
        if (rst_n && out_valid && out_ready)
            sb.check_result('{sample_index, time_ms, raw_sample, centered_sample,
                              level, smoothed_level, baseline_whole, gate_open});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input logic c, input logic [11:0] s, input logic [31:0] t);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= c;
        sample         <= s;
        sample_time_us <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // drop valid, drain every outstanding result, then give the divider time to finish
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input abet_pkg::cfg_index_t idx, input logic [16:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [12:0] thr, input logic [16:0] sf,
                                input logic [16:0] bf, input logic rb,
                                input logic [11:0] ib);
        settle();
        write_reg(abet_pkg::CFG_QUIET_THRESHOLD, 17'(thr));
        write_reg(abet_pkg::CFG_SMOOTHING_FACTOR, sf);
        write_reg(abet_pkg::CFG_BASELINE_FACTOR, bf);
        write_reg(abet_pkg::CFG_REBASE_ENABLE, 17'(rb));
        write_reg(abet_pkg::CFG_INITIAL_BASELINE, 17'(ib));
        cfg_write <= 1'b0;
    endtask

    function automatic logic [16:0] pick_factor(input int k);
        case (k)
            0:       return 17'd0;
            1:       return 17'd1;
            2:       return 17'd65535;
            3:       return abet_pkg::ONE_Q16;
            4:       return 17'h1FFFF;
            5:       return 17'($urandom_range(0, 65536));
            default: return 17'($urandom_range(256, 16384));
        endcase
    endfunction

    // mostly clustered around the baseline so both gate branches are hit
    function automatic logic [11:0] near(input int centre, input int spread);
        int v;
        if ($urandom_range(0, 9) == 0)
            return 12'($urandom);
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    task automatic random_phase(input int p, input int n_samples, input bit calm);
        logic [12:0] thr;
        logic [16:0] sf;
        logic [16:0] bf;
        logic        rb;
        logic [11:0] ib;
        int          centre;
        int          spread;
        int          sent;
        case (p % 8)
            0:       thr = 13'd0;
            1:       thr = 13'd1;
            2:       thr = 13'($urandom_range(0, 64));
            3:       thr = 13'($urandom_range(0, 4095));
            4:       thr = 13'd4095;
            5:       thr = 13'd4096;
            6:       thr = 13'd8191;
            default: thr = 13'($urandom_range(0, 200));
        endcase
        sf = pick_factor((p + 3) % 8);
        bf = pick_factor((p + 5) % 8);
        rb = (p % 4 == 0);
        case (p % 3)
            0:       ib = 12'd4095;
            1:       ib = 12'd0;
            default: ib = 12'($urandom);
        endcase
        centre = rb ? int'($urandom_range(0, 4095)) : int'(ib);
        case ($urandom_range(0, 3))
            0:       spread = 4;
            1:       spread = 64;
            2:       spread = 600;
            default: spread = 4095;
        endcase
        program_regs(thr, sf, bf, rb, ib);
        gap_pct   = calm ? 0 : 10 * $urandom_range(0, 3);
        stall_pct = calm ? 0 : 10 * $urandom_range(0, 3);

        send_item(abet_pkg::CMD_RESTART, 12'($urandom), $urandom);
        if (rb)
            repeat (CAL_LENGTH) send_item(CMD_SAMPLE, near(centre, spread), $urandom);
        for (sent = 0; sent < n_samples; sent++)
        begin
            if (!rb && $urandom_range(0, 49) == 0)
                send_item(abet_pkg::CMD_RESTART, 12'($urandom), $urandom);
            send_item(CMD_SAMPLE, near(centre, spread), $urandom);
        end
    endtask

    initial
    begin
        int p;
        sb = new();
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= abet_pkg::CFG_QUIET_THRESHOLD;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        cmd            <= CMD_SAMPLE;
        sample         <= '0;
        sample_time_us <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration armed by reset, full-scale samples give the largest sum
        gap_pct   = 20;
        stall_pct = 20;
        repeat (CAL_LENGTH) send_item(CMD_SAMPLE, 12'hFFF, $urandom);
        send_item(CMD_SAMPLE, 12'd0, 32'd0);
        send_item(CMD_SAMPLE, 12'hFFF, 32'hFFFF_FFFF);

        // unit weights, baseline factor above one saturates
        program_regs(13'd100, abet_pkg::ONE_Q16, 17'h1FFFF, 1'b0, 12'd0);
        send_item(abet_pkg::CMD_RESTART, 12'hFFF, 32'hFFFF_FFFF);
        send_item(CMD_SAMPLE, 12'd0, 32'd0);
        send_item(CMD_SAMPLE, 12'hFFF, 32'hFFFF_FFFF);
        send_item(CMD_SAMPLE, 12'd99, 32'd999);
        send_item(CMD_SAMPLE, 12'd0, 32'd1000);
        send_item(CMD_SAMPLE, 12'd50, 32'd1999);

        // threshold above range: everything is quiet
        program_regs(13'h1FFF, 17'd32768, 17'd1, 1'b0, 12'hFFF);
        send_item(abet_pkg::CMD_RESTART, 12'd0, 32'd0);
        send_item(CMD_SAMPLE, 12'd0, 32'd123456);
        send_item(CMD_SAMPLE, 12'hFFF, 32'd4294966999);
        send_item(CMD_SAMPLE, 12'd2048, 32'd1000000);

        // gate edge at threshold one, restart mid-stream resets the index
        program_regs(13'd1, 17'd65535, abet_pkg::ONE_Q16, 1'b0, 12'd2048);
        send_item(abet_pkg::CMD_RESTART, 12'hAAA, 32'h5555_5555);
        send_item(CMD_SAMPLE, 12'd2048, 32'd1);
        send_item(CMD_SAMPLE, 12'd2049, 32'd2);
        send_item(CMD_SAMPLE, 12'd2047, 32'd3);
        send_item(abet_pkg::CMD_RESTART, 12'h555, 32'hAAAA_AAAA);
        send_item(CMD_SAMPLE, 12'hFFF, 32'h8000_0000);
        send_item(CMD_SAMPLE, 12'd0, 32'h7FFF_FFFF);

        for (p = 0; p < 12; p++)
            random_phase(p, 100, p == 11);

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/abet_pkg.sv
rtl/core/abet_ema.sv
rtl/core/abet_cal_div.sv
rtl/core/audio_baseline_envelope_tracker.sv
sim/tb_audio_baseline_envelope_tracker.sv
